/* hdl/bkm_pkg.sv */
// ---------------------------------------------------------------------------
// Button-to-key matrix mapper package
// Shared constants, operation codes, the per-slot evaluation record and the
// default binding tables.
// ---------------------------------------------------------------------------
package bkm_pkg;

   // Build-time defaults for the top-level parameters.
   localparam int SLOTS_DEF       = 24;
   localparam int MATRIX_ROWS_DEF = 16;
   localparam int DEFAULT_SET_DEF = 0;

   // Field widths fixed by the interface.
   localparam int HELD_W   = 24;
   localparam int KEY_W    = 8;
   localparam int ROW_W    = 4;
   localparam int COUNT_W  = 5;
   localparam int OP_W     = 2;
   localparam int DEFAULT_COUNT = 6;

   // Key code that marks a slot as unbound or the arm as cleared.
   localparam logic [KEY_W-1:0] UNBOUND = 8'hff;

   // Slot count after reset.
   localparam logic [COUNT_W-1:0] ACTIVE_RESET = 5'd10;

   // Operation codes of an input item.
   localparam logic [OP_W-1:0] OP_POLL    = 2'd0;
   localparam logic [OP_W-1:0] OP_ARM     = 2'd1;
   localparam logic [OP_W-1:0] OP_RESTORE = 2'd2;
   localparam logic [OP_W-1:0] OP_NONE    = 2'd3;

   // What the slot unit decides for the slot under the scan pointer.
   typedef struct packed {
      logic             take_arm; // armed key lands on this slot
      logic             hit;      // this slot changes one matrix bit
      logic             down;     // press when set, release when clear
      logic [KEY_W-1:0] key;      // key code in force for this slot
   } slot_eval_type;

   // Default key code of one slot for the chosen default set.
   function automatic logic [KEY_W-1:0] default_key(input int set, input int idx);
      logic [KEY_W-1:0] code;
      code = UNBOUND;
      if (set == 0) begin
         unique case (idx)
            0: code = 8'h92;
            1: code = 8'h93;
            2: code = 8'h91;
            3: code = 8'h90;
            4: code = 8'h95;
            5: code = 8'h94;
            default: code = UNBOUND;
         endcase
      end else begin
         unique case (idx)
            0: code = 8'h10;
            1: code = 8'h01;
            2: code = 8'h02;
            3: code = 8'h00;
            4: code = 8'h57;
            5: code = 8'h85;
            default: code = UNBOUND;
         endcase
      end
      return code;
   endfunction

endpackage

/* hdl/button_to_key_matrix_mapper.sv */
// ---------------------------------------------------------------------------
// Button-to-key matrix mapper
// Maps held gamepad buttons onto an active-low keyboard matrix through a
// rebindable per-slot key table, with one matrix change per poll.
// ---------------------------------------------------------------------------
//
//   Channel  Direction  Handshake             Carries
//   req_     in         req_valid/req_stall   operation, held buttons, bind key
//   rsp_     out        rsp_valid/rsp_stall   matrix change and binding report
//   csr_     in         csr_wr_en             active slot count
//
// A poll that differs from the pressed mask is accepted, then the shared slot
// unit visits one slot at a time (at most the active slot count, fewer when
// the change and any binding are found early), then the result is loaded.
// Arm, restore, idle codes and unchanged polls give their item the cycle after
// acceptance. Reset is synchronous and loads the default table, a released
// matrix, a zero pressed mask and a cleared arm. The block takes no item while
// scanning or while a result waits under rsp_stall.
// ---------------------------------------------------------------------------
module button_to_key_matrix_mapper #(
   parameter int SLOTS       = bkm_pkg::SLOTS_DEF,
   parameter int MATRIX_ROWS = bkm_pkg::MATRIX_ROWS_DEF,
   parameter int DEFAULT_SET = bkm_pkg::DEFAULT_SET_DEF
) (
   input  logic                        clock,
   input  logic                        reset,
   // Configuration
   input  logic                        csr_wr_en,
   input  logic [bkm_pkg::COUNT_W-1:0] csr_wr_data,
   // Input items
   input  logic                        req_valid,
   output logic                        req_stall,
   input  logic [bkm_pkg::OP_W-1:0]    req_operation,
   input  logic [bkm_pkg::HELD_W-1:0]  req_held_buttons,
   input  logic [bkm_pkg::KEY_W-1:0]   req_bind_key,
   // Result items
   output logic                        rsp_valid,
   input  logic                        rsp_stall,
   output logic                        rsp_matrix_changed,
   output logic [bkm_pkg::ROW_W-1:0]   rsp_matrix_row,
   output logic [bkm_pkg::KEY_W-1:0]   rsp_row_value,
   output logic                        rsp_key_went_down,
   output logic                        rsp_binding_done,
   output logic [bkm_pkg::COUNT_W-1:0] rsp_bound_slot
);
   import bkm_pkg::*;

   localparam int SLOT_IDX_W = (SLOTS > 1) ? $clog2(SLOTS) : 1;
   localparam int ROW_IDX_W  = (MATRIX_ROWS > 1) ? $clog2(MATRIX_ROWS) : 1;
   localparam int SCAN_MAX_I = (SLOTS < HELD_W) ? SLOTS : HELD_W;
   localparam logic [COUNT_W-1:0] SCAN_MAX = COUNT_W'(SCAN_MAX_I);

   // Sequencer codes.
   localparam logic [1:0] ST_IDLE = 2'd0;
   localparam logic [1:0] ST_SCAN = 2'd1;
   localparam logic [1:0] ST_DONE = 2'd2;

   // Control state.
   logic [1:0]         state_ff;
   logic [COUNT_W-1:0] active_ff;
   logic [COUNT_W-1:0] cnt_ff;
   logic [HELD_W-1:0]  pressed_ff;
   logic [KEY_W-1:0]   armed_ff;
   logic [KEY_W-1:0]   key_table_ff [SLOTS];
   logic [KEY_W-1:0]   matrix_ff    [MATRIX_ROWS];

   // Item being scanned and what the scan has found so far.
   logic [HELD_W-1:0]  held_ff;
   logic               chg_ff;
   logic [ROW_W-1:0]   row_ff;
   logic [KEY_W-1:0]   val_ff;
   logic               down_ff;
   logic               bound_ff;
   logic [COUNT_W-1:0] bslot_ff;

   // Output register.
   logic               rsp_valid_ff;
   logic               rsp_chg_ff;
   logic [ROW_W-1:0]   rsp_row_ff;
   logic [KEY_W-1:0]   rsp_val_ff;
   logic               rsp_down_ff;
   logic               rsp_bound_ff;
   logic [COUNT_W-1:0] rsp_bslot_ff;

   logic               accept;
   logic               out_free;
   logic               start_scan;
   logic               rsp_load;
   logic [COUNT_W-1:0] limit;
   logic [COUNT_W-1:0] cnt_in;
   logic               scan_last;
   logic [SLOT_IDX_W-1:0] slot_idx;
   logic [ROW_IDX_W-1:0]  row_idx;
   logic [KEY_W-1:0]   row_cur;
   logic [KEY_W-1:0]   row_new;
   logic [KEY_W-1:0]   bit_mask;
   slot_eval_type      slot_eval;

   // Handshake: items enter only in idle with the output register free.
   assign out_free  = !rsp_valid_ff || !rsp_stall;
   assign req_stall = (state_ff != ST_IDLE) || !out_free;
   assign accept    = req_valid && !req_stall;

   // Number of slots the scan covers.
   assign limit = (active_ff > SCAN_MAX) ? SCAN_MAX : active_ff;

   assign start_scan = (req_operation == OP_POLL) && (req_held_buttons != pressed_ff) &&
                       (limit != '0);

   // A result is loaded for a finished scan or for an item that needs no scan.
   assign rsp_load = (accept && !start_scan) || ((state_ff == ST_DONE) && out_free);

   // Shared slot unit at the scan pointer.
   assign slot_idx = cnt_ff[SLOT_IDX_W-1:0];

   bkm_slot_unit #(
      .MATRIX_ROWS(MATRIX_ROWS)
   ) u_slot (
      .table_key   (key_table_ff[slot_idx]),
      .armed_key   (armed_ff),
      .held_bit    (held_ff[cnt_ff]),
      .pressed_bit (pressed_ff[cnt_ff]),
      .change_found(chg_ff),
      .slot_eval   (slot_eval)
   );

   // Read-modify-write of the matrix row named by the slot's key.
   assign row_idx  = slot_eval.key[KEY_W-ROW_W +: ROW_IDX_W];
   assign row_cur  = matrix_ff[row_idx];
   assign bit_mask = KEY_W'(1) << slot_eval.key[2:0];
   assign row_new  = slot_eval.down ? (row_cur & ~bit_mask) : (row_cur | bit_mask);

   // Stop after the last slot, or once the change is found and no arm is pending.
   assign cnt_in    = cnt_ff + COUNT_W'(1);
   assign scan_last = (cnt_in >= limit) ||
                      ((chg_ff || slot_eval.hit) &&
                       (slot_eval.take_arm || armed_ff == UNBOUND));

   // Sequencer, state and output register.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         active_ff    <= ACTIVE_RESET;
         cnt_ff       <= '0;
         pressed_ff   <= '0;
         armed_ff     <= UNBOUND;
         chg_ff       <= 1'b0;
         bound_ff     <= 1'b0;
         rsp_valid_ff <= 1'b0;
         for (int i = 0; i < SLOTS; i++) begin
            key_table_ff[i] <= default_key(DEFAULT_SET, i);
         end
         for (int r = 0; r < MATRIX_ROWS; r++) begin
            matrix_ff[r] <= '1;
         end
      end else begin
         if (csr_wr_en) begin
            active_ff <= csr_wr_data;
         end
         // The result stays valid until it is taken or replaced.
         if (rsp_load) begin
            rsp_valid_ff <= 1'b1;
         end else if (!rsp_stall) begin
            rsp_valid_ff <= 1'b0;
         end
         unique case (state_ff)
            ST_IDLE: begin
               if (accept) begin
                  if (req_operation == OP_ARM) begin
                     armed_ff <= req_bind_key;
                  end
                  if (req_operation == OP_RESTORE) begin
                     for (int i = 0; i < SLOTS; i++) begin
                        key_table_ff[i] <= default_key(DEFAULT_SET, i);
                     end
                  end
                  if (start_scan) begin
                     held_ff  <= req_held_buttons;
                     cnt_ff   <= '0;
                     chg_ff   <= 1'b0;
                     row_ff   <= '0;
                     val_ff   <= '0;
                     down_ff  <= 1'b0;
                     bound_ff <= 1'b0;
                     bslot_ff <= '0;
                     state_ff <= ST_SCAN;
                  end else begin
                     // Every other item reports nothing.
                     rsp_chg_ff   <= 1'b0;
                     rsp_row_ff   <= '0;
                     rsp_val_ff   <= '0;
                     rsp_down_ff  <= 1'b0;
                     rsp_bound_ff <= 1'b0;
                     rsp_bslot_ff <= '0;
                  end
               end
            end
            ST_SCAN: begin
               if (slot_eval.take_arm) begin
                  key_table_ff[slot_idx] <= armed_ff;
                  armed_ff               <= UNBOUND;
                  bound_ff               <= 1'b1;
                  bslot_ff               <= cnt_ff;
               end
               if (slot_eval.hit) begin
                  matrix_ff[row_idx]  <= row_new;
                  pressed_ff[cnt_ff]  <= slot_eval.down;
                  chg_ff              <= 1'b1;
                  row_ff              <= slot_eval.key[KEY_W-1 -: ROW_W];
                  val_ff              <= row_new;
                  down_ff             <= slot_eval.down;
               end
               cnt_ff <= cnt_in;
               if (scan_last) begin
                  state_ff <= ST_DONE;
               end
            end
            ST_DONE: begin
               if (out_free) begin
                  rsp_chg_ff   <= chg_ff;
                  rsp_row_ff   <= row_ff;
                  rsp_val_ff   <= val_ff;
                  rsp_down_ff  <= down_ff;
                  rsp_bound_ff <= bound_ff;
                  rsp_bslot_ff <= bslot_ff;
                  state_ff     <= ST_IDLE;
               end
            end
            default: begin
               state_ff <= ST_IDLE;
            end
         endcase
      end
   end

   assign rsp_valid          = rsp_valid_ff;
   assign rsp_matrix_changed = rsp_chg_ff;
   assign rsp_matrix_row     = rsp_row_ff;
   assign rsp_row_value      = rsp_val_ff;
   assign rsp_key_went_down  = rsp_down_ff;
   assign rsp_binding_done   = rsp_bound_ff;
   assign rsp_bound_slot     = rsp_bslot_ff;

   // A binding during the scan always clears the arm.
   a_bind_disarms: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_SCAN && slot_eval.take_arm) |=> (armed_ff == UNBOUND))
      else $error("arm still set after a binding");

   // Once a change is recorded the pressed mask stays put for the rest of the poll.
   a_one_change: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_SCAN && chg_ff) |=> $stable(pressed_ff))
      else $error("second matrix change within one poll");

   // While scanning without a change, held and pressed must still differ.
   a_scan_has_work: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_SCAN) |-> (chg_ff || held_ff != pressed_ff))
      else $error("scan running with nothing to change");

   // A reported binding leaves the block disarmed.
   a_done_bound: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_DONE && bound_ff) |-> (armed_ff == UNBOUND))
      else $error("binding reported while still armed");

endmodule

/* hdl/bkm_slot_unit.sv */
// ---------------------------------------------------------------------------
// Button-to-key matrix mapper slot unit
// Evaluates one button slot per cycle: whether the armed key binds here and
// whether the slot's held state differs from its pressed state on a valid key.
// ---------------------------------------------------------------------------
module bkm_slot_unit #(
   parameter int MATRIX_ROWS = bkm_pkg::MATRIX_ROWS_DEF
) (
   input  logic [bkm_pkg::KEY_W-1:0] table_key,
   input  logic [bkm_pkg::KEY_W-1:0] armed_key,
   input  logic                      held_bit,
   input  logic                      pressed_bit,
   input  logic                      change_found,
   output bkm_pkg::slot_eval_type    slot_eval
);
   import bkm_pkg::*;

   localparam logic [ROW_W:0] ROW_LIMIT = (ROW_W + 1)'(MATRIX_ROWS);

   logic             bind_here;
   logic [KEY_W-1:0] key_now;
   logic             key_usable;

   // The first held slot takes the armed key, which then counts for this slot.
   assign bind_here = (armed_key != UNBOUND) && held_bit;
   assign key_now   = bind_here ? armed_key : table_key;

   // Unbound keys and rows past the matrix are skipped.
   assign key_usable = (key_now != UNBOUND) &&
                       ({1'b0, key_now[KEY_W-1:KEY_W-ROW_W]} < ROW_LIMIT);

   always_comb begin
      slot_eval.take_arm = bind_here;
      slot_eval.hit      = !change_found && (held_bit != pressed_bit) && key_usable;
      slot_eval.down     = held_bit;
      slot_eval.key      = key_now;
   end

endmodule

/* test/tb_top.sv */
`timescale 1ns / 100ps
// ---------------------------------------------------------------------------
// Button-to-key matrix mapper testbench
// Drives polls, arm and restore items with random pacing on both channels,
// predicts every report from a behavioral copy of the table, pressed mask,
// matrix and arm, and checks each report field by field across several
// slot-count settings.
// ---------------------------------------------------------------------------
module tb_top;
   import bkm_pkg::*;

   localparam int SCAN_MAX    = HELD_W;
   localparam int ROW_COUNT   = MATRIX_ROWS_DEF;
   localparam int GAP_MAX     = 14;
   localparam int PHASE_ITEMS = 216;
   localparam int TAIL_CYCLES = 40;
   localparam int DRAIN_LIMIT = 5000;

   // Default codes of slots 0 to 5, slot 0 in the low byte.
   localparam logic [DEFAULT_COUNT*KEY_W-1:0] FACTORY_KEYS =
      {8'h94, 8'h95, 8'h90, 8'h91, 8'h93, 8'h92};

   typedef struct packed {
      logic               changed;
      logic [ROW_W-1:0]   row;
      logic [KEY_W-1:0]   value;
      logic               down;
      logic               bound;
      logic [COUNT_W-1:0] slot;
   } key_report_type;

   typedef struct {
      logic [OP_W-1:0]   op;
      logic [HELD_W-1:0] held;
      logic [KEY_W-1:0]  key;
      bit                typed;
      key_report_type    report;
   } directed_row_type;

   // Block ports.
   logic               clock = 1'b0;
   logic               reset = 1'b1;
   logic               csr_wr_en = 1'b0;
   logic [COUNT_W-1:0] csr_wr_data = '0;
   logic               req_valid = 1'b0;
   logic               req_stall;
   logic [OP_W-1:0]    req_operation = OP_NONE;
   logic [HELD_W-1:0]  req_held_buttons = '0;
   logic [KEY_W-1:0]   req_bind_key = '0;
   logic               rsp_valid;
   logic               rsp_stall = 1'b0;
   logic               rsp_matrix_changed;
   logic [ROW_W-1:0]   rsp_matrix_row;
   logic [KEY_W-1:0]   rsp_row_value;
   logic               rsp_key_went_down;
   logic               rsp_binding_done;
   logic [COUNT_W-1:0] rsp_bound_slot;

   // Predicted state of the mapper.
   logic [KEY_W-1:0]   bind_table [SCAN_MAX];
   logic [HELD_W-1:0]  pressed_state;
   logic [KEY_W-1:0]   matrix_rows [ROW_COUNT];
   logic [KEY_W-1:0]   armed_code;
   logic [COUNT_W-1:0] active_count;

   key_report_type pending_reports [$];
   bit          quiet_stretch = 1'b0;
   int          mismatches = 0;
   int          items_sent = 0;
   int          reports_seen = 0;
   int          changes_seen = 0;
   int          bindings_seen = 0;
   int          settings_used = 0;

   button_to_key_matrix_mapper dut (
      .clock              (clock),
      .reset              (reset),
      .csr_wr_en          (csr_wr_en),
      .csr_wr_data        (csr_wr_data),
      .req_valid          (req_valid),
      .req_stall          (req_stall),
      .req_operation      (req_operation),
      .req_held_buttons   (req_held_buttons),
      .req_bind_key       (req_bind_key),
      .rsp_valid          (rsp_valid),
      .rsp_stall          (rsp_stall),
      .rsp_matrix_changed (rsp_matrix_changed),
      .rsp_matrix_row     (rsp_matrix_row),
      .rsp_row_value      (rsp_row_value),
      .rsp_key_went_down  (rsp_key_went_down),
      .rsp_binding_done   (rsp_binding_done),
      .rsp_bound_slot     (rsp_bound_slot)
   );

   // 10 ns clock.
   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // Hard stop in case the block hangs.
   initial begin
      #5000000;
      $display("FAIL button_to_key_matrix_mapper");
      $finish;
   end

   // Load the default bindings into the predicted table.
   function automatic void restore_table();
      int i;
      for (i = 0; i < SCAN_MAX; i++) begin
         bind_table[i] = (i < DEFAULT_COUNT) ? FACTORY_KEYS[i*KEY_W +: KEY_W] : UNBOUND;
      end
   endfunction

   // Report of a poll that changed one matrix bit and bound nothing.
   function automatic key_report_type matrix_report(input logic [ROW_W-1:0] row,
                                                    input logic [KEY_W-1:0] value,
                                                    input logic down);
      key_report_type r;
      r = '0;
      r.changed = 1'b1;
      r.row     = row;
      r.value   = value;
      r.down    = down;
      return r;
   endfunction

   // Apply one item to the predicted state and return the report it causes.
   function automatic key_report_type predict_report(input logic [OP_W-1:0] op,
                                                     input logic [HELD_W-1:0] held,
                                                     input logic [KEY_W-1:0] key_in);
      key_report_type r;
      int          lim;
      int          n;
      logic [KEY_W-1:0] code;
      logic [ROW_W-1:0] row;
      r = '0;
      lim = (active_count > SCAN_MAX) ? SCAN_MAX : int'(active_count);
      case (op)
         OP_ARM: begin
            armed_code = key_in;
         end
         OP_RESTORE: begin
            restore_table();
         end
         OP_POLL: begin
            if (held != pressed_state) begin
               // The armed key goes to the lowest held scanned slot.
               if (armed_code != UNBOUND) begin
                  for (n = 0; n < lim && !r.bound; n++) begin
                     if (held[n]) begin
                        bind_table[n] = armed_code;
                        armed_code = UNBOUND;
                        r.bound = 1'b1;
                        r.slot = COUNT_W'(n);
                     end
                  end
               end
               // The lowest differing slot with a usable key moves one bit.
               for (n = 0; n < lim && !r.changed; n++) begin
                  code = bind_table[n];
                  row = code[KEY_W-1:4];
                  if (held[n] != pressed_state[n] && code != UNBOUND
                      && int'(row) < ROW_COUNT) begin
                     if (held[n]) begin
                        matrix_rows[row][code[2:0]] = 1'b0;
                        pressed_state[n] = 1'b1;
                        r.down = 1'b1;
                     end else begin
                        matrix_rows[row][code[2:0]] = 1'b1;
                        pressed_state[n] = 1'b0;
                     end
                     r.changed = 1'b1;
                     r.row = row;
                     r.value = matrix_rows[row];
                  end
               end
            end
         end
         default: begin
         end
      endcase
      return r;
   endfunction

   // Cycles to wait before the next item on either side.
   function automatic int draw_wait();
      return quiet_stretch ? 0 : $urandom_range(0, GAP_MAX);
   endfunction

   // Offer one item, wait for it to be taken and record its expected report.
   task automatic send_item(input logic [OP_W-1:0] op, input logic [HELD_W-1:0] held,
                            input logic [KEY_W-1:0] key, input bit typed,
                            input key_report_type typed_report);
      int             gap;
      key_report_type predicted;
      gap = draw_wait();
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid        <= 1'b1;
      req_operation    <= op;
      req_held_buttons <= held;
      req_bind_key     <= key;
      do @(posedge clock); while (req_stall);
      predicted = predict_report(op, held, key);
      pending_reports.push_back(typed ? typed_report : predicted);
      items_sent++;
   endtask

   // Stop sending and wait until every expected report has arrived.
   task automatic hold_until_drained();
      req_valid <= 1'b0;
      while (pending_reports.size() != 0) @(posedge clock);
   endtask

   task automatic report_field(input string label, input int unsigned want,
                               input int unsigned got);
      if (want != got) begin
         $display("%0t: %s mismatch, expected %0h, actual %0h", $time, label, want, got);
         mismatches++;
      end
   endtask

   // Result side: random stalls, then check each report against the oldest expectation.
   initial begin : report_monitor
      key_report_type wanted;
      int             pause;
      wait (reset == 1'b0);
      forever begin
         pause = draw_wait();
         if (pause > 0) begin
            rsp_stall <= 1'b1;
            repeat (pause) @(posedge clock);
         end
         rsp_stall <= 1'b0;
         do @(posedge clock); while (!rsp_valid);
         reports_seen++;
         if (rsp_matrix_changed) changes_seen++;
         if (rsp_binding_done) bindings_seen++;
         if (pending_reports.size() == 0) begin
            $display("%0t: report with no item waiting, expected none, actual changed=%0b",
                     $time, rsp_matrix_changed);
            mismatches++;
         end else begin
            wanted = pending_reports.pop_front();
            report_field("matrix_changed", wanted.changed, rsp_matrix_changed);
            report_field("matrix_row", wanted.row, rsp_matrix_row);
            report_field("row_value", wanted.value, rsp_row_value);
            report_field("key_went_down", wanted.down, rsp_key_went_down);
            report_field("binding_done", wanted.bound, rsp_binding_done);
            report_field("bound_slot", wanted.slot, rsp_bound_slot);
         end
      end
   end

   // Stimulus: directed table first, then random phases at several slot counts.
   initial begin : stimulus
      directed_row_type   rows [$];
      logic [COUNT_W-1:0] settings [$];
      logic [HELD_W-1:0]  last_held;
      logic [HELD_W-1:0]  held;
      key_report_type     blank;
      int                 pick;
      int                 span;
      int                 k;
      int                 i;

      blank = '0;
      last_held = '0;
      restore_table();
      pressed_state = '0;
      for (i = 0; i < ROW_COUNT; i++) matrix_rows[i] = 8'hff;
      armed_code = UNBOUND;
      active_count = ACTIVE_RESET;

      repeat (2) @(posedge clock);
      reset <= 1'b0;

      // Directed items; typed reports only where they are obvious.
      rows.push_back('{OP_POLL, 24'h000000, 8'hff, 1'b1, blank});
      rows.push_back('{OP_NONE, 24'hffffff, 8'hff, 1'b1, blank});
      rows.push_back('{OP_POLL, 24'h000001, 8'h00, 1'b1, matrix_report(4'd9, 8'hfb, 1'b1)});
      rows.push_back('{OP_POLL, 24'h000000, 8'h00, 1'b1, matrix_report(4'd9, 8'hff, 1'b0)});
      rows.push_back('{OP_ARM, 24'h000000, 8'h00, 1'b1, blank});
      rows.push_back('{OP_POLL, 24'h800000, 8'h00, 1'b1, blank});
      rows.push_back('{OP_POLL, 24'hc00000, 8'h00, 1'b1, blank});
      rows.push_back('{OP_POLL, 24'h000200, 8'h00, 1'b0, blank});
      rows.push_back('{OP_POLL, 24'h000000, 8'h00, 1'b0, blank});
      rows.push_back('{OP_ARM, 24'hffffff, 8'hff, 1'b1, blank});
      rows.push_back('{OP_POLL, 24'h0003ff, 8'hff, 1'b0, blank});
      rows.push_back('{OP_POLL, 24'h0003ff, 8'h00, 1'b0, blank});
      rows.push_back('{OP_RESTORE, 24'h000000, 8'h00, 1'b1, blank});
      rows.push_back('{OP_ARM, 24'h000000, 8'hf7, 1'b1, blank});
      rows.push_back('{OP_POLL, 24'hffffff, 8'h00, 1'b0, blank});
      rows.push_back('{OP_POLL, 24'h000000, 8'h00, 1'b0, blank});
      rows.push_back('{OP_POLL, 24'h000000, 8'h00, 1'b0, blank});
      rows.push_back('{OP_RESTORE, 24'h5a5a5a, 8'hff, 1'b1, blank});
      rows.push_back('{OP_ARM, 24'h000000, 8'h80, 1'b1, blank});
      rows.push_back('{OP_POLL, 24'haaaaaa, 8'h00, 1'b0, blank});
      rows.push_back('{OP_POLL, 24'h555555, 8'h00, 1'b0, blank});
      rows.push_back('{OP_NONE, 24'h000000, 8'h00, 1'b1, blank});
      rows.push_back('{OP_POLL, 24'h000000, 8'h00, 1'b0, blank});
      foreach (rows[i]) begin
         send_item(rows[i].op, rows[i].held, rows[i].key, rows[i].typed, rows[i].report);
      end
      last_held = '0;

      // Slot counts for the random phases, the extremes among them.
      settings = '{5'd24, 5'd0, 5'd1, 5'd31, 5'd10, 5'd24, 5'd5, 5'd17, 5'd24};
      settings[6] = COUNT_W'($urandom_range(2, 30));

      foreach (settings[i]) begin
         hold_until_drained();
         csr_wr_data <= settings[i];
         csr_wr_en   <= 1'b1;
         @(posedge clock);
         csr_wr_en   <= 1'b0;
         active_count = settings[i];
         settings_used++;
         span = (settings[i] == 0 || settings[i] > SCAN_MAX) ? SCAN_MAX : int'(settings[i]);

         for (k = 0; k < PHASE_ITEMS; k++) begin
            if ($urandom_range(0, 39) == 0) quiet_stretch = !quiet_stretch;
            // Let the block run dry once in the middle of every phase.
            if (k == PHASE_ITEMS / 2) hold_until_drained();
            pick = $urandom_range(0, 99);
            if (pick < 70) begin
               // Typical play: one or two buttons change inside the scan window, or anywhere when the count is zero.
               held = last_held ^ (24'h1 << $urandom_range(0, span - 1));
               if ($urandom_range(0, 3) == 0) held ^= 24'h1 << $urandom_range(0, span - 1);
               send_item(OP_POLL, held, KEY_W'($urandom), 1'b0, blank);
               last_held = held;
            end else if (pick < 75) begin
               send_item(OP_POLL, last_held, KEY_W'($urandom), 1'b0, blank);
            end else if (pick < 82) begin
               held = HELD_W'($urandom);
               send_item(OP_POLL, held, KEY_W'($urandom), 1'b0, blank);
               last_held = held;
            end else if (pick < 90) begin
               send_item(OP_ARM, HELD_W'($urandom),
                         ($urandom_range(0, 5) == 0) ? UNBOUND : KEY_W'($urandom),
                         1'b0, blank);
            end else if (pick < 94) begin
               send_item(OP_RESTORE, HELD_W'($urandom), KEY_W'($urandom), 1'b0, blank);
            end else if (pick < 97) begin
               send_item(OP_NONE, HELD_W'($urandom), KEY_W'($urandom), 1'b0, blank);
            end else begin
               send_item(OP_POLL, '0, KEY_W'($urandom), 1'b0, blank);
               last_held = '0;
            end
         end
      end

      // Wait for the last reports, with a bound.
      req_valid <= 1'b0;
      for (k = 0; k < DRAIN_LIMIT && pending_reports.size() != 0; k++) @(posedge clock);
      if (pending_reports.size() != 0) begin
         $display("%0t: %0d reports still expected, actual none arrived",
                  $time, pending_reports.size());
         mismatches += pending_reports.size();
      end
      repeat (TAIL_CYCLES) @(posedge clock);

      $display("Sent %0d items over %0d slot-count settings and checked %0d reports.",
               items_sent, settings_used + 1, reports_seen);
      $display("Reports carried %0d matrix changes and %0d bindings; %0d mismatches.",
               changes_seen, bindings_seen, mismatches);
      if (mismatches == 0) begin
         $display("PASS button_to_key_matrix_mapper");
      end else begin
         $display("FAIL button_to_key_matrix_mapper");
      end
      $finish;
   end

endmodule
